// File: rtl/weighted_splat_accumulator_top_macros.svh
// assertion macros used by the splat accumulator controller
`ifndef WEIGHTED_SPLAT_ACCUMULATOR_TOP_MACROS_SVH
`define WEIGHTED_SPLAT_ACCUMULATOR_TOP_MACROS_SVH

// same-cycle implication, checked on clk and masked during reset
`define WSA_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define WSA_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/wsa_pkg.sv
// shared types and constants of the splat accumulator
`timescale 1ns / 1ps
package wsa_pkg;

	localparam int MAX_WIDTH  = 256;
	localparam int MAX_HEIGHT = 256;
	localparam int PIX_N      = MAX_WIDTH * MAX_HEIGHT;
	localparam int PIX_W      = $clog2(PIX_N);
	localparam int DIM_MAX    = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
	localparam int DIM_W      = $clog2(DIM_MAX + 1);
	localparam int COORD_W    = 8;
	localparam int CFG_DIM_W  = 9;
	localparam int GAIN_W     = 24;
	localparam int DIV_HI_W   = 40;
	localparam int DIV_LO_W   = 32;

	localparam logic [16:0] ALPHA_ONE = 17'd65536;

	typedef enum logic [1:0] {
		FUNC_SPLAT = 2'd0,
		FUNC_READ  = 2'd1,
		FUNC_CLEAR = 2'd2,
		FUNC_NONE  = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		DIV_CLAMP = 2'd0,
		DIV_MEAN  = 2'd1,
		DIV_PROD  = 2'd2,
		DIV_ALPHA = 2'd3
	} div_sel_t;

	typedef enum logic [1:0] {
		REG_WIDTH   = 2'd0,
		REG_HEIGHT  = 2'd1,
		REG_MAX_LUM = 2'd2,
		REG_GAIN    = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [39:0] weight;
		logic [39:0] alpha;
		logic [47:0] ax;
		logic [47:0] ay;
		logic [47:0] az;
	} pix_entry_t;

	typedef struct packed {
		logic     capture;
		logic     decode;
		logic     index;
		logic     clr;
		logic     cl_mul;
		logic     div_start;
		logic     div_wait;
		div_sel_t div_sel;
		logic     alpha;
		logic     term;
		logic     accum;
		logic     rd_mem;
		logic     rd_mul;
		logic     rd_sum;
		logic     out_load;
		logic [1:0] ch;
	} cmd_t;

	typedef struct packed {
		func_t func;
		logic  land;
		logic  clamp;
		logic  wzero;
		logic  mean_ok;
		logic  div_done;
		logic  clr_last;
	} status_t;

endpackage

// File: rtl/wsa_div.sv
// restoring divider, one quotient bit per cycle, 32-bit saturated quotient
`timescale 1ns / 1ps
module wsa_div (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [wsa_pkg::DIV_HI_W-1:0]   hi,
	input  logic [wsa_pkg::DIV_LO_W-1:0]   lo,
	input  logic [wsa_pkg::DIV_HI_W-1:0]   den,
	output logic                           done,
	output logic [wsa_pkg::DIV_LO_W-1:0]   quo
);

	localparam int CNT_W = $clog2(wsa_pkg::DIV_LO_W);

	logic                          busy_q;
	logic                          done_q;
	logic [CNT_W-1:0]              cnt_q;
	logic [wsa_pkg::DIV_HI_W-1:0]  rem_q;
	logic [wsa_pkg::DIV_LO_W-1:0]  quo_q;
	logic [wsa_pkg::DIV_HI_W-1:0]  den_q;
	logic [wsa_pkg::DIV_HI_W:0]    trial;
	logic [wsa_pkg::DIV_HI_W:0]    diff;
	logic                          ge;

	assign trial = {rem_q, quo_q[wsa_pkg::DIV_LO_W-1]};
	assign diff  = trial - {1'b0, den_q};
	assign ge    = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= '0;
				if (hi >= den) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					busy_q <= 1'b1;
				end
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(wsa_pkg::DIV_LO_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			den_q <= den;
			if (hi >= den) begin
				quo_q <= '1;
			end else begin
				rem_q <= hi;
				quo_q <= lo;
			end
		end else if (busy_q) begin
			rem_q <= ge ? diff[wsa_pkg::DIV_HI_W-1:0] : trial[wsa_pkg::DIV_HI_W-1:0];
			quo_q <= {quo_q[wsa_pkg::DIV_LO_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

// File: rtl/wsa_datapath.sv
// datapath: pixel store, arithmetic units and result registers
`timescale 1ns / 1ps
module wsa_datapath (
	input  logic                             clk,
	input  logic                             arst_n,
	input  wsa_pkg::cmd_t                    cmd,
	output wsa_pkg::status_t                 status,
	input  logic [1:0]                       func,
	input  logic signed [16:0]               pos_x,
	input  logic signed [16:0]               pos_y,
	input  logic [31:0]                      rad_x,
	input  logic [31:0]                      rad_y,
	input  logic [31:0]                      rad_z,
	input  logic [23:0]                      sample_weight,
	input  logic [16:0]                      sample_alpha,
	input  logic [15:0]                      read_index,
	input  logic [wsa_pkg::CFG_DIM_W-1:0]    cfg_width,
	input  logic [wsa_pkg::CFG_DIM_W-1:0]    cfg_height,
	input  logic [31:0]                      cfg_max_lum,
	input  logic [wsa_pkg::GAIN_W-1:0]       cfg_gain,
	output logic                             hit,
	output logic [15:0]                      pixel_index,
	output logic [31:0]                      out_x,
	output logic [31:0]                      out_y,
	output logic [31:0]                      out_z,
	output logic [16:0]                      out_alpha,
	output logic [31:0]                      scene_max_lum,
	output logic                             box_valid,
	output logic [7:0]                       box_min_x,
	output logic [7:0]                       box_min_y,
	output logic [7:0]                       box_max_x,
	output logic [7:0]                       box_max_y
);

	localparam int DW = wsa_pkg::DIM_W;
	localparam int CW = wsa_pkg::COORD_W;
	localparam int PW = wsa_pkg::PIX_W;

	// request capture
	wsa_pkg::func_t   func_q;
	logic [16:0]      px_q, py_q;
	logic [31:0]      rx_q, ry_q, rz_q;
	logic [23:0]      wt_q;
	logic [16:0]      al_q;
	logic [15:0]      ridx_q;

	// working registers
	logic [CW-1:0]    i_q, j_q;
	logic             land_q, clamp_q;
	logic [PW-1:0]    k_q;
	logic [63:0]      prod_q;
	logic [23:0]      ac_q;
	logic [39:0]      term_q [3];
	logic [39:0]      wsum_q;
	logic [47:0]      ysum_q;
	logic [47:0]      plo_q, phi_q;
	logic [71:0]      p72_q;
	logic             hit_q;
	logic [PW-1:0]    pix_q;
	logic [31:0]      ox_q, oy_q, oz_q;
	logic [16:0]      oa_q;

	// persistent state
	logic [PW-1:0]    clr_q;
	logic [31:0]      max_q;
	logic             bv_q;
	logic [CW-1:0]    bx0_q, by0_q, bx1_q, by1_q;

	// result registers
	logic             res_hit_q;
	logic [15:0]      res_pix_q;
	logic [31:0]      res_x_q, res_y_q, res_z_q, res_max_q;
	logic [16:0]      res_a_q;
	logic             res_bv_q;
	logic [7:0]       res_bx0_q, res_by0_q, res_bx1_q, res_by1_q;

	wsa_pkg::pix_entry_t mem [wsa_pkg::PIX_N];
	wsa_pkg::pix_entry_t rd_q;
	wsa_pkg::pix_entry_t wr_data;
	logic                wr_en;
	logic [PW-1:0]       wr_addr;

	logic [DW-1:0]       w_eff, h_eff;
	logic [2*DW-1:0]     area;
	logic [16+DW-1:0]    pxw, pyw;
	logic [DW-1:0]       i_full, j_full;
	logic                splat_land, read_land;
	logic [2*DW-1:0]     kw;
	logic [16:0]         al_sat;
	logic [40:0]         ac_full;
	logic [31:0]         term_r;
	logic [55:0]         term_p;
	logic [47:0]         rd_acc;
	logic [40:0]         w_new, a_new;
	logic [48:0]         x_new, y_new, z_new;
	wsa_pkg::pix_entry_t acc_ent;

	logic                           div_done;
	logic [wsa_pkg::DIV_LO_W-1:0]   div_quo;
	logic [wsa_pkg::DIV_HI_W-1:0]   div_hi, div_den;
	logic [wsa_pkg::DIV_LO_W-1:0]   div_lo;

	// effective resolution
	always_comb begin
		if (cfg_width == '0)
			w_eff = DW'(1);
		else if (DW'(cfg_width) > DW'(wsa_pkg::MAX_WIDTH))
			w_eff = DW'(wsa_pkg::MAX_WIDTH);
		else
			w_eff = DW'(cfg_width);
		if (cfg_height == '0)
			h_eff = DW'(1);
		else if (DW'(cfg_height) > DW'(wsa_pkg::MAX_HEIGHT))
			h_eff = DW'(wsa_pkg::MAX_HEIGHT);
		else
			h_eff = DW'(cfg_height);
	end

	assign area       = w_eff * h_eff;
	assign pxw        = px_q[15:0] * w_eff;
	assign pyw        = py_q[15:0] * h_eff;
	assign i_full     = pxw[16+DW-1:16];
	assign j_full     = pyw[16+DW-1:16];
	assign splat_land = !px_q[16] && !py_q[16] && (i_full < w_eff) && (j_full < h_eff);
	assign read_land  = (2*DW)'(ridx_q) < area;
	assign kw         = j_q * w_eff + (2*DW)'(i_q);

	assign al_sat  = (al_q > wsa_pkg::ALPHA_ONE) ? wsa_pkg::ALPHA_ONE : al_q;
	assign ac_full = wt_q * al_sat;

	always_comb begin
		case (cmd.ch)
			2'd0:    term_r = rx_q;
			2'd1:    term_r = ry_q;
			default: term_r = rz_q;
		endcase
		case (cmd.ch)
			2'd0:    rd_acc = rd_q.ax;
			2'd1:    rd_acc = rd_q.ay;
			default: rd_acc = rd_q.az;
		endcase
	end

	assign term_p = ac_q * term_r;

	// saturating accumulation
	assign w_new = {1'b0, rd_q.weight} + 41'(wt_q);
	assign a_new = {1'b0, rd_q.alpha} + 41'(ac_q);
	assign x_new = {1'b0, rd_q.ax} + 49'(term_q[0]);
	assign y_new = {1'b0, rd_q.ay} + 49'(term_q[1]);
	assign z_new = {1'b0, rd_q.az} + 49'(term_q[2]);

	always_comb begin
		acc_ent.weight = w_new[40] ? '1 : w_new[39:0];
		acc_ent.alpha  = a_new[40] ? '1 : a_new[39:0];
		acc_ent.ax     = x_new[48] ? '1 : x_new[47:0];
		acc_ent.ay     = y_new[48] ? '1 : y_new[47:0];
		acc_ent.az     = z_new[48] ? '1 : z_new[47:0];
	end

	// divider operand selection
	always_comb begin
		case (cmd.div_sel)
			wsa_pkg::DIV_CLAMP: begin
				div_hi  = 40'(prod_q[63:32]);
				div_lo  = prod_q[31:0];
				div_den = 40'(ry_q);
			end
			wsa_pkg::DIV_MEAN: begin
				div_hi  = 40'(ysum_q[47:16]);
				div_lo  = {ysum_q[15:0], 16'd0};
				div_den = wsum_q;
			end
			wsa_pkg::DIV_PROD: begin
				div_hi  = p72_q[71:32];
				div_lo  = p72_q[31:0];
				div_den = rd_q.weight;
			end
			default: begin
				div_hi  = 40'(rd_q.alpha[39:16]);
				div_lo  = {rd_q.alpha[15:0], 16'd0};
				div_den = rd_q.weight;
			end
		endcase
	end

	wsa_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.hi     (div_hi),
		.lo     (div_lo),
		.den    (div_den),
		.done   (div_done),
		.quo    (div_quo)
	);

	// pixel store
	assign wr_en   = cmd.clr || cmd.accum;
	assign wr_addr = cmd.clr ? clr_q : k_q;
	assign wr_data = cmd.clr ? '0 : acc_ent;

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
		if (cmd.alpha || cmd.rd_mem)
			rd_q <= mem[k_q];
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
			max_q <= '0;
			bv_q  <= 1'b0;
			bx0_q <= '0;
			by0_q <= '0;
			bx1_q <= '0;
			by1_q <= '0;
		end else begin
			if (cmd.clr) begin
				clr_q <= clr_q + 1'b1;
				max_q <= '0;
				bv_q  <= 1'b0;
				bx0_q <= '0;
				by0_q <= '0;
				bx1_q <= '0;
				by1_q <= '0;
			end
			if (cmd.div_wait && div_done && cmd.div_sel == wsa_pkg::DIV_MEAN &&
			    div_quo > max_q)
				max_q <= div_quo;
			if (cmd.accum) begin
				bv_q <= 1'b1;
				if (!bv_q) begin
					bx0_q <= i_q;
					bx1_q <= i_q;
					by0_q <= j_q;
					by1_q <= j_q;
				end else begin
					if (i_q < bx0_q)
						bx0_q <= i_q;
					if (i_q > bx1_q)
						bx1_q <= i_q;
					if (j_q < by0_q)
						by0_q <= j_q;
					if (j_q > by1_q)
						by1_q <= j_q;
				end
			end
		end
	end

	// working payload
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			func_q <= wsa_pkg::func_t'(func);
			px_q   <= pos_x;
			py_q   <= pos_y;
			rx_q   <= rad_x;
			ry_q   <= rad_y;
			rz_q   <= rad_z;
			wt_q   <= sample_weight;
			al_q   <= sample_alpha;
			ridx_q <= read_index;
		end
		if (cmd.decode) begin
			i_q     <= i_full[CW-1:0];
			j_q     <= j_full[CW-1:0];
			clamp_q <= ry_q > cfg_max_lum;
			ox_q    <= '0;
			oy_q    <= '0;
			oz_q    <= '0;
			oa_q    <= '0;
			unique case (func_q)
				wsa_pkg::FUNC_SPLAT: land_q <= splat_land;
				wsa_pkg::FUNC_READ:  land_q <= read_land;
				wsa_pkg::FUNC_CLEAR: land_q <= 1'b0;
				wsa_pkg::FUNC_NONE:  land_q <= 1'b0;
			endcase
		end
		if (cmd.index) begin
			k_q   <= (func_q == wsa_pkg::FUNC_READ) ? PW'(ridx_q) : kw[PW-1:0];
			hit_q <= land_q;
			if (!land_q)
				pix_q <= '0;
			else if (func_q == wsa_pkg::FUNC_READ)
				pix_q <= PW'(ridx_q);
			else
				pix_q <= kw[PW-1:0];
		end
		if (cmd.cl_mul)
			prod_q <= ((cmd.ch == 2'd0) ? rx_q : rz_q) * cfg_max_lum;
		if (cmd.alpha) begin
			ac_q <= ac_full[39:16];
			if (clamp_q)
				ry_q <= cfg_max_lum;
		end
		if (cmd.term)
			term_q[cmd.ch] <= term_p[55:16];
		if (cmd.accum) begin
			wsum_q <= acc_ent.weight;
			ysum_q <= acc_ent.ay;
		end
		if (cmd.rd_mul) begin
			plo_q <= rd_acc[23:0] * cfg_gain;
			phi_q <= rd_acc[47:24] * cfg_gain;
		end
		if (cmd.rd_sum)
			p72_q <= {phi_q, 24'd0} + 72'(plo_q);
		if (cmd.div_wait && div_done) begin
			case (cmd.div_sel)
				wsa_pkg::DIV_CLAMP: begin
					if (cmd.ch == 2'd0)
						rx_q <= div_quo;
					else
						rz_q <= div_quo;
				end
				wsa_pkg::DIV_PROD: begin
					case (cmd.ch)
						2'd0:    ox_q <= div_quo;
						2'd1:    oy_q <= div_quo;
						default: oz_q <= div_quo;
					endcase
				end
				wsa_pkg::DIV_ALPHA:
					oa_q <= (div_quo > 32'(wsa_pkg::ALPHA_ONE)) ? wsa_pkg::ALPHA_ONE :
						div_quo[16:0];
				default: ;
			endcase
		end
		if (cmd.out_load) begin
			res_hit_q <= hit_q && (func_q == wsa_pkg::FUNC_SPLAT ||
				func_q == wsa_pkg::FUNC_READ);
			res_pix_q <= (func_q == wsa_pkg::FUNC_SPLAT || func_q == wsa_pkg::FUNC_READ) ?
				16'(pix_q) : 16'd0;
			res_x_q   <= ox_q;
			res_y_q   <= oy_q;
			res_z_q   <= oz_q;
			res_a_q   <= oa_q;
			res_max_q <= max_q;
			res_bv_q  <= bv_q;
			res_bx0_q <= bv_q ? 8'(bx0_q) : 8'd0;
			res_by0_q <= bv_q ? 8'(by0_q) : 8'd0;
			res_bx1_q <= bv_q ? 8'(bx1_q) : 8'd0;
			res_by1_q <= bv_q ? 8'(by1_q) : 8'd0;
		end
	end

	always_comb begin
		status.func     = func_q;
		status.land     = land_q;
		status.clamp    = clamp_q;
		status.wzero    = rd_q.weight == '0;
		status.mean_ok  = (wsum_q != '0) && (ysum_q != '0);
		status.div_done = div_done;
		status.clr_last = clr_q == '1;
	end

	assign hit           = res_hit_q;
	assign pixel_index   = res_pix_q;
	assign out_x         = res_x_q;
	assign out_y         = res_y_q;
	assign out_z         = res_z_q;
	assign out_alpha     = res_a_q;
	assign scene_max_lum = res_max_q;
	assign box_valid     = res_bv_q;
	assign box_min_x     = res_bx0_q;
	assign box_min_y     = res_by0_q;
	assign box_max_x     = res_bx1_q;
	assign box_max_y     = res_by1_q;

endmodule

// File: rtl/wsa_ctrl.sv
// controller state machine sequencing each request through the datapath
`timescale 1ns / 1ps
`include "weighted_splat_accumulator_top_macros.svh"
module wsa_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	output logic              out_valid,
	input  logic              out_stall,
	input  wsa_pkg::status_t  status,
	output wsa_pkg::cmd_t     cmd
);

	typedef enum logic [16:0] {
		ST_IDLE     = 17'h00001,
		ST_DECODE   = 17'h00002,
		ST_INDEX    = 17'h00004,
		ST_CLR      = 17'h00008,
		ST_CL_MUL   = 17'h00010,
		ST_CL_DIV   = 17'h00020,
		ST_ALPHA    = 17'h00040,
		ST_TERM     = 17'h00080,
		ST_ACCUM    = 17'h00100,
		ST_MEAN_DIV = 17'h00200,
		ST_RD_MEM   = 17'h00400,
		ST_RD_CHK   = 17'h00800,
		ST_RD_MUL   = 17'h01000,
		ST_RD_SUM   = 17'h02000,
		ST_RD_DIV   = 17'h04000,
		ST_RD_ADIV  = 17'h08000,
		ST_DONE     = 17'h10000
	} state_t;

	state_t      state_q, state_nxt;
	logic [1:0]  ch_q, ch_nxt;
	logic        issued_q, issued_nxt;
	logic        item_q;
	logic        out_valid_q;
	logic        accept;

	assign accept   = in_valid && (state_q == ST_IDLE);
	assign in_stall = state_q != ST_IDLE;

	always_comb begin
		state_nxt  = state_q;
		ch_nxt     = ch_q;
		issued_nxt = issued_q;
		cmd        = '0;
		cmd.ch     = ch_q;
		cmd.capture = accept;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid)
					state_nxt = ST_DECODE;
			end
			ST_DECODE: begin
				cmd.decode = 1'b1;
				state_nxt  = ST_INDEX;
			end
			ST_INDEX: begin
				cmd.index = 1'b1;
				ch_nxt    = 2'd0;
				unique case (status.func)
					wsa_pkg::FUNC_SPLAT:
						state_nxt = !status.land ? ST_DONE :
							(status.clamp ? ST_CL_MUL : ST_ALPHA);
					wsa_pkg::FUNC_READ:
						state_nxt = status.land ? ST_RD_MEM : ST_DONE;
					wsa_pkg::FUNC_CLEAR:
						state_nxt = ST_CLR;
					wsa_pkg::FUNC_NONE:
						state_nxt = ST_DONE;
				endcase
			end
			ST_CLR: begin
				cmd.clr = 1'b1;
				if (status.clr_last)
					state_nxt = item_q ? ST_DONE : ST_IDLE;
			end
			ST_CL_MUL: begin
				cmd.cl_mul = 1'b1;
				state_nxt  = ST_CL_DIV;
			end
			ST_CL_DIV: begin
				cmd.div_sel  = wsa_pkg::DIV_CLAMP;
				cmd.div_wait = issued_q;
				if (!issued_q) begin
					cmd.div_start = 1'b1;
					issued_nxt    = 1'b1;
				end else if (status.div_done) begin
					issued_nxt = 1'b0;
					if (ch_q == 2'd0) begin
						ch_nxt    = 2'd1;
						state_nxt = ST_CL_MUL;
					end else begin
						ch_nxt    = 2'd0;
						state_nxt = ST_ALPHA;
					end
				end
			end
			ST_ALPHA: begin
				cmd.alpha = 1'b1;
				state_nxt = ST_TERM;
			end
			ST_TERM: begin
				cmd.term = 1'b1;
				if (ch_q == 2'd2) begin
					ch_nxt    = 2'd0;
					state_nxt = ST_ACCUM;
				end else begin
					ch_nxt = ch_q + 2'd1;
				end
			end
			ST_ACCUM: begin
				cmd.accum = 1'b1;
				state_nxt = ST_MEAN_DIV;
			end
			ST_MEAN_DIV: begin
				cmd.div_sel  = wsa_pkg::DIV_MEAN;
				cmd.div_wait = issued_q;
				if (!issued_q) begin
					if (status.mean_ok) begin
						cmd.div_start = 1'b1;
						issued_nxt    = 1'b1;
					end else begin
						state_nxt = ST_DONE;
					end
				end else if (status.div_done) begin
					issued_nxt = 1'b0;
					state_nxt  = ST_DONE;
				end
			end
			ST_RD_MEM: begin
				cmd.rd_mem = 1'b1;
				state_nxt  = ST_RD_CHK;
			end
			ST_RD_CHK: begin
				state_nxt = status.wzero ? ST_DONE : ST_RD_MUL;
			end
			ST_RD_MUL: begin
				cmd.rd_mul = 1'b1;
				state_nxt  = ST_RD_SUM;
			end
			ST_RD_SUM: begin
				cmd.rd_sum = 1'b1;
				state_nxt  = ST_RD_DIV;
			end
			ST_RD_DIV: begin
				cmd.div_sel  = wsa_pkg::DIV_PROD;
				cmd.div_wait = issued_q;
				if (!issued_q) begin
					cmd.div_start = 1'b1;
					issued_nxt    = 1'b1;
				end else if (status.div_done) begin
					issued_nxt = 1'b0;
					if (ch_q == 2'd2) begin
						ch_nxt    = 2'd0;
						state_nxt = ST_RD_ADIV;
					end else begin
						ch_nxt    = ch_q + 2'd1;
						state_nxt = ST_RD_MUL;
					end
				end
			end
			ST_RD_ADIV: begin
				cmd.div_sel  = wsa_pkg::DIV_ALPHA;
				cmd.div_wait = issued_q;
				if (!issued_q) begin
					cmd.div_start = 1'b1;
					issued_nxt    = 1'b1;
				end else if (status.div_done) begin
					issued_nxt = 1'b0;
					state_nxt  = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!out_valid_q || !out_stall) begin
					cmd.out_load = 1'b1;
					state_nxt    = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLR;
			ch_q        <= 2'd0;
			issued_q    <= 1'b0;
			item_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q  <= state_nxt;
			ch_q     <= ch_nxt;
			issued_q <= issued_nxt;
			if (accept)
				item_q <= 1'b1;
			else if (cmd.out_load)
				item_q <= 1'b0;
			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

	`WSA_ASSERT_IMP(a_div_done_issued, status.div_done, issued_q, "divider finished unasked")
	`WSA_ASSERT_NXT(a_accept_decode, accept, state_q == ST_DECODE, "request not decoded")
	`WSA_ASSERT_NXT(a_load_valid, cmd.out_load, out_valid_q, "result loaded but not shown")

endmodule

// File: rtl/weighted_splat_accumulator_top.sv
// Weighted splat accumulator: per-pixel weighted sample store with readout
//
// Requests enter on in_valid/in_stall with func: splat a sample, read a pixel
// or clear the buffer, or do nothing. Each request yields exactly one result on
// out_valid/out_stall, carrying the running max mean luminance and dirty box.
// The block works one request at a time. Divisions per request, all on the
// shared 32-step restoring divider, which saturates the quotient on overflow:
//   splat: up to two clamp divisions and a mean division; none when dropped
//   read: three product and one alpha division; none for zero weight or bad index
//   clear: no division, one pixel of the store cleared per cycle
// A finished result sits in an output register; the next request is taken
// while it waits. If the receiver stalls, the result holds and a following
// result waits in the controller until the register frees.
// After reset the block sweeps the pixel store clear with
// in_stall high; configuration writes over APB are taken at any time.
// Registers: 0x0 width, 0x4 height, 0x8 max sample luminance, 0xC read gain.
`timescale 1ns / 1ps
module weighted_splat_accumulator_top (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [3:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [1:0]          func,
	input  logic signed [16:0]  pos_x,
	input  logic signed [16:0]  pos_y,
	input  logic [31:0]         rad_x,
	input  logic [31:0]         rad_y,
	input  logic [31:0]         rad_z,
	input  logic [23:0]         sample_weight,
	input  logic [16:0]         sample_alpha,
	input  logic [15:0]         read_index,
	output logic                out_valid,
	input  logic                out_stall,
	output logic                hit,
	output logic [15:0]         pixel_index,
	output logic [31:0]         out_x,
	output logic [31:0]         out_y,
	output logic [31:0]         out_z,
	output logic [16:0]         out_alpha,
	output logic [31:0]         scene_max_lum,
	output logic                box_valid,
	output logic [7:0]          box_min_x,
	output logic [7:0]          box_min_y,
	output logic [7:0]          box_max_x,
	output logic [7:0]          box_max_y
);

	logic [wsa_pkg::CFG_DIM_W-1:0] width_q, height_q;
	logic [31:0]                   max_lum_q;
	logic [wsa_pkg::GAIN_W-1:0]    gain_q;
	wsa_pkg::reg_idx_t             reg_idx;
	logic                          wr;
	wsa_pkg::cmd_t                 cmd;
	wsa_pkg::status_t              status;

	assign pready  = 1'b1;
	assign reg_idx = wsa_pkg::reg_idx_t'(paddr[3:2]);
	assign wr      = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q   <= wsa_pkg::CFG_DIM_W'(256);
			height_q  <= wsa_pkg::CFG_DIM_W'(256);
			max_lum_q <= '1;
			gain_q    <= wsa_pkg::GAIN_W'(65536);
		end else if (wr) begin
			unique case (reg_idx)
				wsa_pkg::REG_WIDTH:   width_q   <= pwdata[wsa_pkg::CFG_DIM_W-1:0];
				wsa_pkg::REG_HEIGHT:  height_q  <= pwdata[wsa_pkg::CFG_DIM_W-1:0];
				wsa_pkg::REG_MAX_LUM: max_lum_q <= pwdata;
				wsa_pkg::REG_GAIN:    gain_q    <= pwdata[wsa_pkg::GAIN_W-1:0];
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			wsa_pkg::REG_WIDTH:   prdata = 32'(width_q);
			wsa_pkg::REG_HEIGHT:  prdata = 32'(height_q);
			wsa_pkg::REG_MAX_LUM: prdata = max_lum_q;
			wsa_pkg::REG_GAIN:    prdata = 32'(gain_q);
		endcase
	end

	wsa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.cmd       (cmd)
	);

	wsa_datapath u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.func          (func),
		.pos_x         (pos_x),
		.pos_y         (pos_y),
		.rad_x         (rad_x),
		.rad_y         (rad_y),
		.rad_z         (rad_z),
		.sample_weight (sample_weight),
		.sample_alpha  (sample_alpha),
		.read_index    (read_index),
		.cfg_width     (width_q),
		.cfg_height    (height_q),
		.cfg_max_lum   (max_lum_q),
		.cfg_gain      (gain_q),
		.hit           (hit),
		.pixel_index   (pixel_index),
		.out_x         (out_x),
		.out_y         (out_y),
		.out_z         (out_z),
		.out_alpha     (out_alpha),
		.scene_max_lum (scene_max_lum),
		.box_valid     (box_valid),
		.box_min_x     (box_min_x),
		.box_min_y     (box_min_y),
		.box_max_x     (box_max_x),
		.box_max_y     (box_max_y)
	);

endmodule

// File: tb/sv/wsa_checker.sv
// splat accumulator checker: predicts each result from the observed requests and compares
`timescale 1ns / 1ps
module wsa_checker
	import wsa_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [3:0]         paddr,
	input  logic [31:0]        pwdata,
	input  logic               pready,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic [1:0]         func,
	input  logic signed [16:0] pos_x,
	input  logic signed [16:0] pos_y,
	input  logic [31:0]        rad_x,
	input  logic [31:0]        rad_y,
	input  logic [31:0]        rad_z,
	input  logic [23:0]        sample_weight,
	input  logic [16:0]        sample_alpha,
	input  logic [15:0]        read_index,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic               hit,
	input  logic [15:0]        pixel_index,
	input  logic [31:0]        out_x,
	input  logic [31:0]        out_y,
	input  logic [31:0]        out_z,
	input  logic [16:0]        out_alpha,
	input  logic [31:0]        scene_max_lum,
	input  logic               box_valid,
	input  logic [7:0]         box_min_x,
	input  logic [7:0]         box_min_y,
	input  logic [7:0]         box_max_x,
	input  logic [7:0]         box_max_y,
	output int                 errors,
	output int                 pending
);

	localparam logic [63:0] LIM32 = 64'hFFFF_FFFF;
	localparam logic [63:0] LIM40 = 64'hFF_FFFF_FFFF;
	localparam logic [63:0] LIM48 = 64'hFFFF_FFFF_FFFF;

	typedef struct packed {
		logic        hit;
		logic [15:0] pix;
		logic [31:0] ox;
		logic [31:0] oy;
		logic [31:0] oz;
		logic [16:0] oa;
		logic [31:0] max_lum;
		logic        bv;
		logic [7:0]  bx0;
		logic [7:0]  by0;
		logic [7:0]  bx1;
		logic [7:0]  by1;
	} pix_result_t;

	logic [8:0]  cfg_width, cfg_height;
	logic [31:0] cfg_max_lum;
	logic [23:0] cfg_gain;

	logic [63:0] wsum[int];
	logic [63:0] asum[int];
	logic [63:0] xsum[int];
	logic [63:0] ysum[int];
	logic [63:0] zsum[int];
	logic [31:0] lum_peak;
	logic        dirty;
	logic [7:0]  dx0, dy0, dx1, dy1;

	pix_result_t expected_results[$];

	function automatic logic [63:0] sat_add(logic [63:0] a, logic [63:0] b, logic [63:0] lim);
		logic [63:0] s;
		s = a + b;
		return (s > lim) ? lim : s;
	endfunction

	function automatic logic [31:0] quot_sat(logic [127:0] num, logic [63:0] d);
		logic [127:0] q;
		q = num / d;
		return (q > LIM32) ? LIM32[31:0] : q[31:0];
	endfunction

	function automatic logic [63:0] dim_of(logic [8:0] v, int lim);
		if (v == 0)
			return 1;
		return (v > lim) ? lim : v;
	endfunction

	function automatic void wipe_buffer();
		wsum.delete();
		asum.delete();
		xsum.delete();
		ysum.delete();
		zsum.delete();
		lum_peak = '0;
		dirty = 1'b0;
		{dx0, dy0, dx1, dy1} = '0;
	endfunction

	function automatic pix_result_t splat_and_read(func_t f);
		pix_result_t r;
		logic [63:0] w_dim, h_dim, px, py, ci, cj, rx, ry, rz, wt, al, ac, k, mean;
		logic [127:0] num;
		r = '0;
		w_dim = dim_of(cfg_width, MAX_WIDTH);
		h_dim = dim_of(cfg_height, MAX_HEIGHT);
		case (f)
			FUNC_SPLAT: begin
				px = {47'd0, pos_x};
				py = {47'd0, pos_y};
				if (!px[16] && !py[16]) begin
					ci = (px * w_dim) >> 16;
					cj = (py * h_dim) >> 16;
					if (ci < w_dim && cj < h_dim) begin
						rx = rad_x;
						ry = rad_y;
						rz = rad_z;
						if (ry > cfg_max_lum) begin
							rx = rx * cfg_max_lum / ry;
							rz = rz * cfg_max_lum / ry;
							ry = cfg_max_lum;
						end
						al = (sample_alpha > ALPHA_ONE) ? 64'd65536 : sample_alpha;
						wt = sample_weight;
						ac = (wt * al) >> 16;
						k = cj * w_dim + ci;
						if (!wsum.exists(int'(k))) begin
							wsum[int'(k)] = 0;
							asum[int'(k)] = 0;
							xsum[int'(k)] = 0;
							ysum[int'(k)] = 0;
							zsum[int'(k)] = 0;
						end
						wsum[int'(k)] = sat_add(wsum[int'(k)], wt, LIM40);
						asum[int'(k)] = sat_add(asum[int'(k)], ac, LIM40);
						xsum[int'(k)] = sat_add(xsum[int'(k)], (ac * rx) >> 16, LIM48);
						ysum[int'(k)] = sat_add(ysum[int'(k)], (ac * ry) >> 16, LIM48);
						zsum[int'(k)] = sat_add(zsum[int'(k)], (ac * rz) >> 16, LIM48);
						if (wsum[int'(k)] > 0 && ysum[int'(k)] > 0) begin
							mean = quot_sat({64'd0, ysum[int'(k)] << 16}, wsum[int'(k)]);
							if (mean > lum_peak)
								lum_peak = mean[31:0];
						end
						if (!dirty) begin
							dirty = 1'b1;
							dx0 = ci[7:0];
							dx1 = ci[7:0];
							dy0 = cj[7:0];
							dy1 = cj[7:0];
						end else begin
							if (ci[7:0] < dx0) dx0 = ci[7:0];
							if (ci[7:0] > dx1) dx1 = ci[7:0];
							if (cj[7:0] < dy0) dy0 = cj[7:0];
							if (cj[7:0] > dy1) dy1 = cj[7:0];
						end
						r.hit = 1'b1;
						r.pix = k[15:0];
					end
				end
			end
			FUNC_READ: begin
				k = read_index;
				if (k < w_dim * h_dim) begin
					r.hit = 1'b1;
					r.pix = k[15:0];
					if (wsum.exists(int'(k)) && wsum[int'(k)] > 0) begin
						num = xsum[int'(k)] * cfg_gain;
						r.ox = quot_sat(num, wsum[int'(k)]);
						num = ysum[int'(k)] * cfg_gain;
						r.oy = quot_sat(num, wsum[int'(k)]);
						num = zsum[int'(k)] * cfg_gain;
						r.oz = quot_sat(num, wsum[int'(k)]);
						mean = (asum[int'(k)] << 16) / wsum[int'(k)];
						r.oa = (mean > 65536) ? ALPHA_ONE : mean[16:0];
					end
				end
			end
			FUNC_CLEAR: wipe_buffer();
			default: ;
		endcase
		r.max_lum = lum_peak;
		r.bv = dirty;
		if (dirty) begin
			r.bx0 = dx0;
			r.by0 = dy0;
			r.bx1 = dx1;
			r.by1 = dy1;
		end
		return r;
	endfunction

	function automatic void cmp(string name, logic [31:0] exp_v, logic [31:0] act_v);
		if (exp_v !== act_v) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
			errors++;
		end
	endfunction

	initial begin
		errors = 0;
		pending = 0;
		cfg_width = 9'd256;
		cfg_height = 9'd256;
		cfg_max_lum = 32'hFFFF_FFFF;
		cfg_gain = 24'd65536;
		wipe_buffer();
	end

	always @(posedge clk) begin
		pix_result_t e;
		if (arst_n) begin
			if (psel && penable && pwrite && pready) begin
				case (reg_idx_t'(paddr[3:2]))
					REG_WIDTH:   cfg_width = pwdata[8:0];
					REG_HEIGHT:  cfg_height = pwdata[8:0];
					REG_MAX_LUM: cfg_max_lum = pwdata;
					REG_GAIN:    cfg_gain = pwdata[23:0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall)
				expected_results.push_back(splat_and_read(func_t'(func)));
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					$error("result with no request outstanding");
					errors++;
				end else begin
					e = expected_results.pop_front();
					cmp("hit", e.hit, hit);
					cmp("pixel_index", e.pix, pixel_index);
					cmp("out_x", e.ox, out_x);
					cmp("out_y", e.oy, out_y);
					cmp("out_z", e.oz, out_z);
					cmp("out_alpha", e.oa, out_alpha);
					cmp("scene_max_lum", e.max_lum, scene_max_lum);
					cmp("box_valid", e.bv, box_valid);
					cmp("box_min_x", e.bx0, box_min_x);
					cmp("box_min_y", e.by0, box_min_y);
					cmp("box_max_x", e.bx1, box_max_x);
					cmp("box_max_y", e.by1, box_max_y);
				end
			end
			pending = expected_results.size();
		end
	end

endmodule

// File: tb/sv/tb_top.sv
// splat accumulator testbench top: clock, reset, stimulus and verdict
`timescale 1ns / 1ps
module tb_top;
	import wsa_pkg::*;

	localparam int IDLE_LIMIT = 300000;
	localparam int RAND_PER_PHASE = 215;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [3:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [1:0] func = FUNC_NONE;
	logic signed [16:0] pos_x = '0, pos_y = '0;
	logic [31:0] rad_x = '0, rad_y = '0, rad_z = '0;
	logic [23:0] sample_weight = '0;
	logic [16:0] sample_alpha = '0;
	logic [15:0] read_index = '0;
	logic out_valid;
	logic out_stall = 1'b1;
	logic hit;
	logic [15:0] pixel_index;
	logic [31:0] out_x, out_y, out_z, scene_max_lum;
	logic [16:0] out_alpha;
	logic box_valid;
	logic [7:0] box_min_x, box_min_y, box_max_x, box_max_y;

	int errors, pending;
	int n_sent = 0;
	int idle_cycles = 0;
	int img_w = 256, img_h = 256;
	int landed[$];

	always #1 clk = ~clk;

	weighted_splat_accumulator_top DUT (.*);

	wsa_checker u_checker (.*);

	task automatic reg_write(reg_idx_t idx, logic [31:0] v);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	function automatic int dim(logic [8:0] v, int lim);
		if (v == 0)
			return 1;
		return (v > lim) ? lim : v;
	endfunction

	task automatic setup(logic [8:0] w, logic [8:0] h, logic [31:0] lum, logic [23:0] gain);
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		reg_write(REG_WIDTH, w);
		reg_write(REG_HEIGHT, h);
		reg_write(REG_MAX_LUM, lum);
		reg_write(REG_GAIN, gain);
		img_w = dim(w, MAX_WIDTH);
		img_h = dim(h, MAX_HEIGHT);
		landed.delete();
	endtask

	task automatic send(func_t f, logic signed [16:0] x, logic signed [16:0] y,
			logic [31:0] cx, logic [31:0] cy, logic [31:0] cz, logic [23:0] wt,
			logic [16:0] al, logic [15:0] idx);
		int ci, cj;
		func <= f;
		pos_x <= x;
		pos_y <= y;
		rad_x <= cx;
		rad_y <= cy;
		rad_z <= cz;
		sample_weight <= wt;
		sample_alpha <= al;
		read_index <= idx;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		n_sent++;
		if (f == FUNC_SPLAT && !x[16] && !y[16]) begin
			ci = (int'(x) * img_w) >>> 16;
			cj = (int'(y) * img_h) >>> 16;
			landed.push_back(cj * img_w + ci);
		end
		if (f == FUNC_CLEAR)
			landed.delete();
	endtask

	function automatic logic signed [16:0] coord(int n);
		int c;
		case ($urandom_range(0, 3))
			0: return $urandom_range(0, 65535);
			default: begin
				c = $urandom_range(0, (n > 6) ? 5 : n - 1);
				return ((c * 65536) + n - 1) / n;
			end
		endcase
	endfunction

	function automatic logic [31:0] colour();
		case ($urandom_range(0, 3))
			0: return $urandom;
			1: return $urandom_range(0, 32'h0004_0000);
			default: return $urandom_range(0, 32'h0000_FFFF);
		endcase
	endfunction

	task automatic random_items(int n);
		int r, burst;
		logic [15:0] idx;
		logic [16:0] al;
		burst = $urandom_range(1, 20);
		repeat (n) begin
			r = $urandom_range(0, 999);
			al = ($urandom_range(0, 7) == 0) ? 17'($urandom) : 17'($urandom_range(0, 65536));
			if (r < 560) begin
				send(FUNC_SPLAT, coord(img_w), coord(img_h), colour(), colour(), colour(),
					$urandom, al, $urandom);
			end else if (r < 620) begin
				send(FUNC_SPLAT, $urandom, $urandom, $urandom, $urandom, $urandom,
					$urandom, al, $urandom);
			end else if (r < 960) begin
				if (landed.size() > 0 && $urandom_range(0, 3) != 0)
					idx = landed[$urandom_range(0, landed.size() - 1)];
				else if ($urandom_range(0, 1))
					idx = $urandom_range(0, img_w * img_h - 1);
				else
					idx = $urandom;
				send(FUNC_READ, $urandom, $urandom, $urandom, $urandom, $urandom,
					$urandom, al, idx);
			end else if (r < 995) begin
				send(FUNC_NONE, $urandom, $urandom, $urandom, $urandom, $urandom,
					$urandom, al, $urandom);
			end else begin
				send(FUNC_CLEAR, $urandom, $urandom, $urandom, $urandom, $urandom,
					$urandom, al, $urandom);
			end
			burst--;
			if (burst == 0) begin
				burst = $urandom_range(1, 20);
				if ($urandom_range(0, 2) != 0) begin
					in_valid <= 1'b0;
					repeat ($urandom_range(1, 12)) @(posedge clk);
				end
			end
		end
		in_valid <= 1'b0;
	endtask

	// receiver: changing stall pattern, and one long hold-off once traffic is flowing
	initial begin
		int mode, hold;
		bit held;
		held = 0;
		forever begin
			mode = $urandom_range(0, 3);
			repeat ($urandom_range(20, 200)) begin
				@(posedge clk);
				if (!held && n_sent > 150) begin
					held = 1;
					out_stall <= 1'b1;
					for (hold = 0; hold < 2000; hold++)
						@(posedge clk);
				end
				case (mode)
					0: out_stall <= 1'b0;
					1: out_stall <= ($urandom_range(0, 9) < 3);
					2: out_stall <= ($urandom_range(0, 9) < 8);
					default: out_stall <= $urandom_range(0, 1);
				endcase
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("tb: failure");
				$finish;
			end
		end
	end

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// overflowing readout, zero weight, bad index, spare func, clear
		setup(9'd4, 9'd3, 32'hFFFF_FFFF, 24'hFF_FFFF);
		send(FUNC_SPLAT, 17'sd0, 17'sd0, '1, '1, '1, 24'd1, 17'd65536, '0);
		send(FUNC_READ, '0, '0, '0, '0, '0, '0, '0, 16'd0);
		send(FUNC_SPLAT, 17'sd65535, 17'sd65535, '1, '1, '1, 24'hFF_FFFF, 17'h1FFFF, '1);
		send(FUNC_READ, '1, '1, '1, '1, '1, '1, '1, 16'd11);
		send(FUNC_SPLAT, 17'sd20000, 17'sd0, 32'd5, 32'd7, 32'd9, 24'd0, 17'd40000, '0);
		send(FUNC_READ, '0, '0, '0, '0, '0, '0, '0, 16'd1);
		send(FUNC_READ, '0, '0, '0, '0, '0, '0, '0, 16'd12);
		send(FUNC_READ, '0, '0, '0, '0, '0, '0, '0, 16'hFFFF);
		send(FUNC_READ, '0, '0, '0, '0, '0, '0, '0, 16'd5);
		send(FUNC_NONE, '1, '1, '1, '1, '1, '1, '1, '1);
		send(FUNC_SPLAT, -17'sd65536, 17'sd100, '1, '1, '1, '1, 17'd65536, '0);
		send(FUNC_SPLAT, 17'sd100, -17'sd1, '1, '1, '1, '1, 17'd65536, '0);
		send(FUNC_CLEAR, '0, '0, '0, '0, '0, '0, '0, '0);
		send(FUNC_READ, '0, '0, '0, '0, '0, '0, '0, 16'd11);
		in_valid <= 1'b0;

		// luminance clamp and alpha extremes
		setup(9'd4, 9'd3, 32'h0002_0000, 24'd65536);
		send(FUNC_SPLAT, 17'sd40000, 17'sd30000, 32'h0010_0000, 32'hFFFF_FFFF,
			32'h0003_0000, 24'h01_0000, 17'd0, '0);
		send(FUNC_SPLAT, 17'sd40000, 17'sd30000, 32'hFFFF_FFFF, 32'h0008_0000,
			32'hFFFF_FFFF, 24'h02_0000, 17'd32768, '0);
		send(FUNC_SPLAT, 17'sd40000, 17'sd30000, 32'd1, 32'h0002_0000, 32'd1,
			24'hFF_FFFF, 17'd65537, '0);
		send(FUNC_READ, '0, '0, '0, '0, '0, '0, '0, 16'd6);
		in_valid <= 1'b0;

		setup(9'd0, 9'd511, 32'd0, 24'hFF_FFFF);
		random_items(RAND_PER_PHASE);
		setup(9'd256, 9'd256, $urandom, $urandom);
		random_items(RAND_PER_PHASE);
		setup(9'd7, 9'd5, $urandom_range(0, 32'h0010_0000), 24'd65536);
		random_items(RAND_PER_PHASE);
		setup(9'd511, 9'd0, 32'hFFFF_FFFF, 24'd0);
		random_items(RAND_PER_PHASE);
		setup(9'd1, 9'd1, $urandom, $urandom);
		random_items(RAND_PER_PHASE);

		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

// File: filelist.f
+incdir+rtl
rtl/wsa_pkg.sv
rtl/wsa_div.sv
rtl/wsa_datapath.sv
rtl/wsa_ctrl.sv
rtl/weighted_splat_accumulator_top.sv
tb/sv/wsa_checker.sv
tb/sv/tb_top.sv
